>>> sv/ufct_pkg.sv
// Shared widths, defaults and result type for the union-find component tracker.
`default_nettype none

package ufct_pkg;

	localparam int NODE_W        = 10;
	localparam int COUNT_W       = 11;
	localparam int MAX_NODES_DEF = 1024;

	typedef struct packed {
		logic               merged;
		logic [COUNT_W-1:0] component_total;
		logic [COUNT_W-1:0] largest_set;
		logic               bad_node;
	} result_t;

	typedef struct packed {
		logic load;
		logic slot_free;
	} slot_ctl_t;

endpackage

`default_nettype wire

>>> sv/ufct_if.sv
// Valid/ready channel interfaces for edge items and result items.
`default_nettype none

interface ufct_edge_if
	import ufct_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [NODE_W-1:0] node_a;
	logic [NODE_W-1:0] node_b;

	modport source (output valid, output node_a, output node_b, input ready);
	modport sink   (input valid, input node_a, input node_b, output ready);
endinterface

interface ufct_result_if
	import ufct_pkg::*;
();
	logic               valid;
	logic               ready;
	logic               merged;
	logic [COUNT_W-1:0] component_total;
	logic [COUNT_W-1:0] largest_set;
	logic               bad_node;

	modport source (output valid, output merged, output component_total,
		output largest_set, output bad_node, input ready);
	modport sink   (input valid, input merged, input component_total,
		input largest_set, input bad_node, output ready);
endinterface

`default_nettype wire

>>> sv/ufct_out_slot.sv
// Output register that holds one finished result item until the sink takes it.
`default_nettype none

module ufct_out_slot
	import ufct_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    load,
	input  wire result_t res,
	output slot_ctl_t    ctl,
	ufct_result_if.source result_out
);

	logic    valid_q;
	result_t res_q;

	always_comb begin
		ctl.load      = load;
		ctl.slot_free = !valid_q || result_out.ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			res_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			res_q   <= res;
		end else if (result_out.ready) begin
			valid_q <= 1'b0;
		end
	end

	assign result_out.valid           = valid_q;
	assign result_out.merged          = res_q.merged;
	assign result_out.component_total = res_q.component_total;
	assign result_out.largest_set     = res_q.largest_set;
	assign result_out.bad_node        = res_q.bad_node;

endmodule

`default_nettype wire

>>> sv/union_find_component_tracker.sv
// Top level of the union-find component tracker: sequencer, parent and size memories.
//
// Disjoint-set engine, union by size with path compression. Each edge item
// (node_a, node_b) walks both parent chains to their roots in a parent memory,
// reads the two set sizes, links the smaller root under the larger (on a tie
// the root of node_b goes under the root of node_a) and then rewrites every
// node on both walks to point at the new root. One result item per edge:
// merged, the component count, the largest set size seen, and bad_node when an
// index is not below node_count (the edge is then ignored). An edge that merges
// two sets walks both root chains, reads both sizes, links the roots and then
// compresses both walks; an edge whose ends already share a root stops after
// the two walks, and an out-of-range edge goes straight to its result. The
// parent memory, one read per cycle with registered read data, paces each walk
// and each compression step node by node. A finished item waits while the
// output register is still full. After reset, and after every node_count write,
// a clearing pass over all MAX_NODES entries rewrites both memories while no
// edge is accepted; a finished result waits in an output register so the next
// edge can enter.
`default_nettype none

module union_find_component_tracker
	import ufct_pkg::*;
#(
	parameter int MAX_NODES = MAX_NODES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [COUNT_W-1:0] cfg_wdata,
	ufct_edge_if.sink               edge_in,
	ufct_result_if.source           result_out
);

	localparam int NW = $clog2(MAX_NODES);
	localparam logic [NW-1:0] LAST_NODE = NW'(MAX_NODES - 1);
	// node_count reset value: 1024, or MAX_NODES if that is smaller
	localparam logic [COUNT_W-1:0] NCOUNT_RST =
		(MAX_NODES < 1024) ? COUNT_W'(MAX_NODES) : COUNT_W'(1024);
	// ceiling for written node_count values
	localparam logic [COUNT_W-1:0] NCOUNT_MAX =
		(MAX_NODES > 2047) ? {COUNT_W{1'b1}} : COUNT_W'(MAX_NODES);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_FIND_A,
		S_FIND_B,
		S_SIZE_A,
		S_SIZE_B,
		S_CMP_RD,
		S_CMP_WR,
		S_DONE
	} state_t;

	state_t             state_q;
	logic [NW-1:0]      clr_q;
	logic [COUNT_W-1:0] node_count_q;
	logic [COUNT_W-1:0] comp_q;
	logic [COUNT_W-1:0] largest_q;
	logic [NW-1:0]      a_q, b_q, x_q, ra_q, rb_q, big_q;
	logic [COUNT_W-1:0] sa_q;
	logic               side_q;     // 0: compressing the node_b walk, 1: node_a walk
	logic               merged_q;
	logic               bad_q;

	// parent memory: one write and one read port, registered read data
	logic [NW-1:0]      par_mem [MAX_NODES];
	logic               par_we;
	logic [NW-1:0]      par_waddr, par_wdata, par_raddr, par_rdata_q;

	// set size memory, only meaningful at roots
	logic [COUNT_W-1:0] size_mem [MAX_NODES];
	logic               size_we;
	logic [NW-1:0]      size_waddr, size_raddr;
	logic [COUNT_W-1:0] size_wdata, size_rdata_q;

	logic               accept;
	logic               in_bad;
	logic [COUNT_W-1:0] cfg_count;
	logic [NW-1:0]      link_big, link_small;
	logic [COUNT_W-1:0] link_sum;

	result_t            res;
	slot_ctl_t          slot_ctl;

	assign edge_in.ready = (state_q == S_IDLE);
	assign accept        = edge_in.valid && edge_in.ready;
	assign in_bad        = ({1'b0, edge_in.node_a} >= node_count_q)
		|| ({1'b0, edge_in.node_b} >= node_count_q);

	// clamp a written node count into 1 .. NCOUNT_MAX (MAX_NODES, capped at 2047)
	always_comb begin
		if (cfg_wdata == '0) begin
			cfg_count = COUNT_W'(1);
		end else if (cfg_wdata > NCOUNT_MAX) begin
			cfg_count = NCOUNT_MAX;
		end else begin
			cfg_count = cfg_wdata;
		end
	end

	// union by size: the larger set wins, a tie keeps the node_a root on top
	always_comb begin
		if (size_rdata_q > sa_q) begin
			link_big   = rb_q;
			link_small = ra_q;
		end else begin
			link_big   = ra_q;
			link_small = rb_q;
		end
		link_sum = sa_q + size_rdata_q;
	end

	// memory port steering per sequencer state
	always_comb begin
		par_we     = 1'b0;
		par_waddr  = x_q;
		par_wdata  = big_q;
		par_raddr  = x_q;
		size_we    = 1'b0;
		size_waddr = clr_q;
		size_wdata = COUNT_W'(1);
		size_raddr = ra_q;
		case (state_q)
			S_CLEAR: begin
				par_we     = 1'b1;
				par_waddr  = clr_q;
				par_wdata  = clr_q;
				size_we    = 1'b1;
			end
			S_IDLE: begin
				par_raddr = NW'(edge_in.node_a);
			end
			S_FIND_A: begin
				// on reaching the root, start the node_b walk
				par_raddr = (par_rdata_q == x_q) ? b_q : par_rdata_q;
			end
			S_FIND_B: begin
				par_raddr  = par_rdata_q;
				size_raddr = ra_q;
			end
			S_SIZE_A: begin
				size_raddr = rb_q;
			end
			S_SIZE_B: begin
				par_we     = 1'b1;
				par_waddr  = link_small;
				par_wdata  = link_big;
				size_we    = 1'b1;
				size_waddr = link_big;
				size_wdata = link_sum;
			end
			S_CMP_WR: begin
				// rewrite this node and fetch the next one on the walk
				par_we    = 1'b1;
				par_raddr = par_rdata_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (par_we) begin
			par_mem[par_waddr] <= par_wdata;
		end
		par_rdata_q <= par_mem[par_raddr];
	end

	always_ff @(posedge clk) begin
		if (size_we) begin
			size_mem[size_waddr] <= size_wdata;
		end
		size_rdata_q <= size_mem[size_raddr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			node_count_q <= NCOUNT_RST;
			comp_q       <= NCOUNT_RST;
			largest_q    <= COUNT_W'(1);
			a_q          <= '0;
			b_q          <= '0;
			x_q          <= '0;
			ra_q         <= '0;
			rb_q         <= '0;
			big_q        <= '0;
			sa_q         <= '0;
			side_q       <= 1'b0;
			merged_q     <= 1'b0;
			bad_q        <= 1'b0;
		end else if (cfg_we) begin
			// new node count: reinitialize every set
			node_count_q <= cfg_count;
			comp_q       <= cfg_count;
			largest_q    <= COUNT_W'(1);
			clr_q        <= '0;
			state_q      <= S_CLEAR;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + NW'(1);
					if (clr_q == LAST_NODE) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						a_q      <= NW'(edge_in.node_a);
						b_q      <= NW'(edge_in.node_b);
						x_q      <= NW'(edge_in.node_a);
						merged_q <= 1'b0;
						bad_q    <= in_bad;
						state_q  <= in_bad ? S_DONE : S_FIND_A;
					end
				end
				S_FIND_A: begin
					if (par_rdata_q == x_q) begin
						ra_q    <= x_q;
						x_q     <= b_q;
						state_q <= S_FIND_B;
					end else begin
						x_q <= par_rdata_q;
					end
				end
				S_FIND_B: begin
					if (par_rdata_q == x_q) begin
						rb_q    <= x_q;
						state_q <= (x_q == ra_q) ? S_DONE : S_SIZE_A;
					end else begin
						x_q <= par_rdata_q;
					end
				end
				S_SIZE_A: begin
					sa_q    <= size_rdata_q;
					state_q <= S_SIZE_B;
				end
				S_SIZE_B: begin
					big_q    <= link_big;
					merged_q <= 1'b1;
					if (comp_q > COUNT_W'(1)) begin
						comp_q <= comp_q - COUNT_W'(1);
					end
					if (link_sum > largest_q) begin
						largest_q <= link_sum;
					end
					x_q     <= b_q;
					side_q  <= 1'b0;
					state_q <= S_CMP_RD;
				end
				S_CMP_RD: begin
					if (x_q == big_q) begin
						if (!side_q) begin
							x_q    <= a_q;
							side_q <= 1'b1;
						end else begin
							state_q <= S_DONE;
						end
					end else begin
						state_q <= S_CMP_WR;
					end
				end
				S_CMP_WR: begin
					if (par_rdata_q == big_q) begin
						if (!side_q) begin
							x_q     <= a_q;
							side_q  <= 1'b1;
							state_q <= S_CMP_RD;
						end else begin
							state_q <= S_DONE;
						end
					end else begin
						x_q <= par_rdata_q;
					end
				end
				S_DONE: begin
					// hold until the output register can take the item
					if (slot_ctl.slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		res.merged          = merged_q;
		res.component_total = comp_q;
		res.largest_set     = largest_q;
		res.bad_node        = bad_q;
	end

	ufct_out_slot u_out_slot (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       ((state_q == S_DONE) && slot_ctl.slot_free),
		.res        (res),
		.ctl        (slot_ctl),
		.result_out (result_out)
	);

endmodule

`default_nettype wire
